// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted timer queue
// Holds the widths, the op codes, the queued input word type and the result kind codes.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int DELAY_W = 20;
	localparam int TAG_W   = 8;
	localparam int KIND_W  = 2;
	localparam int TIME_W  = 32;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

	typedef struct packed {
		logic               op;
		logic [DELAY_W-1:0] delay;
		logic [TAG_W-1:0]   tag;
	} item_t;

endpackage

// ===== hdl/stq_front.sv =====
// ----------------------------------------------------------------------------
// stq_front: input side of the sorted timer queue
// Accepts input words into a two-entry queue that feeds the timer engine.
// ----------------------------------------------------------------------------
module stq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stq_pkg::item_t in_item,
	output logic           hd_valid,
	input  logic           hd_take,
	output stq_pkg::item_t hd_item
);

	stq_pkg::item_t buf_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     fill_q;

	logic push;

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign hd_valid = (fill_q != 2'd0);
	assign hd_item  = buf_q[rd_q];

	// store an incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (hd_take) begin
				rd_q <= ~rd_q;
			end
			case ({push, hd_take})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hdl/stq_back.sv =====
// ----------------------------------------------------------------------------
// stq_back: timer engine of the sorted timer queue
// Keeps the sorted row of timer cells and the tick count, inserts added
// timers and pops due timers one per cycle, while the result register is free.
// ----------------------------------------------------------------------------
module stq_back #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        hd_valid,
	output logic                        hd_take,
	input  stq_pkg::item_t              hd_item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [stq_pkg::KIND_W-1:0]  res_kind,
	output logic [stq_pkg::TAG_W-1:0]   res_tag,
	output logic                        res_last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = stq_pkg::TIME_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic [TW-1:0]       dl_q [DEPTH];
	logic [TAG_BITS-1:0] tg_q [DEPTH];
	logic [CW-1:0]       cnt_q;
	logic [TW-1:0]       now_q;
	logic                st_q;

	logic                       ov_q;
	logic [stq_pkg::KIND_W-1:0] okind_q;
	logic [stq_pkg::TAG_W-1:0]  otag_q;
	logic                       olast_q;

	logic [DEPTH-1:0]          lt;
	logic [TAG_BITS-1:0]       tag_in;
	logic [stq_pkg::TAG_W-1:0] tag_in_o;
	logic [stq_pkg::TAG_W-1:0] head_tag_o;
	logic [TW-1:0]             span;
	logic                      ofree;
	logic                      full;
	logic                      do_ins;
	logic                      do_pop;
	logic                      due0;
	logic                      due1;
	logic [TW-1:0]             age0;
	logic [TW-1:0]             age1;

	assign ofree = !ov_q || res_ready;
	assign full  = (cnt_q == CW'(DEPTH));
	assign span  = {{(TW - stq_pkg::DELAY_W){1'b0}}, hd_item.delay};

	// fit tag to stored width and back to port width
	for (genvar b = 0; b < TAG_BITS; b++) begin : g_tin
		if (b < stq_pkg::TAG_W) begin : g_on
			assign tag_in[b] = hd_item.tag[b];
		end else begin : g_off
			assign tag_in[b] = 1'b0;
		end
	end
	for (genvar b = 0; b < stq_pkg::TAG_W; b++) begin : g_tout
		if (b < TAG_BITS) begin : g_on
			assign tag_in_o[b]   = tag_in[b];
			assign head_tag_o[b] = tg_q[0][b];
		end else begin : g_off
			assign tag_in_o[b]   = 1'b0;
			assign head_tag_o[b] = 1'b0;
		end
	end

	// head due tests against the advanced count
	assign age0 = now_q - dl_q[0];
	assign age1 = now_q - dl_q[1];
	assign due0 = (cnt_q != '0) && !age0[TW-1];
	assign due1 = (cnt_q > CW'(1)) && !age1[TW-1];

	// take a word in idle: ticks always, adds once the result register is free
	assign hd_take = hd_valid && (st_q == ST_IDLE)
		&& ((hd_item.op == stq_pkg::OP_TICK) || ofree);
	assign do_ins  = hd_take && (hd_item.op == stq_pkg::OP_ADD) && !full;
	assign do_pop  = (st_q == ST_POP) && due0 && ofree;

	// per-cell compare and shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TW-1:0] rel;
		assign rel   = dl_q[i] - now_q;
		assign lt[i] = (CW'(i) < cnt_q) && (rel < span);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (!lt[0]) begin
						dl_q[0] <= now_q + span;
						tg_q[0] <= tag_in;
					end
				end else if (do_pop) begin
					dl_q[0] <= dl_q[1];
					tg_q[0] <= tg_q[1];
				end
			end
		end else if (i == DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_ins && !lt[i]) begin
					if (lt[i-1]) begin
						dl_q[i] <= now_q + span;
						tg_q[i] <= tag_in;
					end else begin
						dl_q[i] <= dl_q[i-1];
						tg_q[i] <= tg_q[i-1];
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (!lt[i]) begin
						if (lt[i-1]) begin
							dl_q[i] <= now_q + span;
							tg_q[i] <= tag_in;
						end else begin
							dl_q[i] <= dl_q[i-1];
							tg_q[i] <= tg_q[i-1];
						end
					end
				end else if (do_pop) begin
					dl_q[i] <= dl_q[i+1];
					tg_q[i] <= tg_q[i+1];
				end
			end
		end
	end

	// control: count, tick count, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			now_q   <= '0;
			st_q    <= ST_IDLE;
			ov_q    <= 1'b0;
			okind_q <= stq_pkg::KIND_ACCEPT;
			otag_q  <= '0;
			olast_q <= 1'b0;
		end else begin
			if (res_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (hd_take) begin
						if (hd_item.op == stq_pkg::OP_TICK) begin
							now_q <= now_q + TW'(1);
							st_q  <= ST_POP;
						end else begin
							ov_q    <= 1'b1;
							okind_q <= full ? stq_pkg::KIND_FULL : stq_pkg::KIND_ACCEPT;
							otag_q  <= tag_in_o;
							olast_q <= 1'b1;
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
					end
				end
				ST_POP: begin
					if (!due0) begin
						st_q <= ST_IDLE;
					end else if (ofree) begin
						ov_q    <= 1'b1;
						okind_q <= stq_pkg::KIND_EXPIRED;
						otag_q  <= head_tag_o;
						olast_q <= !due1;
						cnt_q   <= cnt_q - CW'(1);
						if (!due1) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = ov_q;
	assign res_kind  = okind_q;
	assign res_tag   = otag_q;
	assign res_last  = olast_q;

endmodule

// ===== hdl/sorted_timer_queue.sv =====
// Order: an accepted word waits in the front queue; an add then writes its
// result register, while a tick advances the count and then pops due expiries.
// Throughput: one add per cycle while the result register is free and no tick
// is popping; expiries follow one per cycle while result_ready is held.
// Reset: arst_n clears the tick count, the queue fill and all handshakes.
// ----------------------------------------------------------------------------
// sorted_timer_queue: deadline-sorted timer list with a tick-driven count
// Input words add timers or advance time; result words acknowledge adds and
// report expired timers in deadline order.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic                        op,
	input  logic [stq_pkg::DELAY_W-1:0] delay,
	input  logic [stq_pkg::TAG_W-1:0]   tag,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [stq_pkg::KIND_W-1:0]  kind,
	output logic [stq_pkg::TAG_W-1:0]   fired_tag,
	output logic                        last
);

	stq_pkg::item_t in_item;
	stq_pkg::item_t hd_item;
	logic           hd_valid;
	logic           hd_take;

	assign in_item.op    = op;
	assign in_item.delay = delay;
	assign in_item.tag   = tag;

	// queue input words
	stq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_ready (item_ready),
		.in_item  (in_item),
		.hd_valid (hd_valid),
		.hd_take  (hd_take),
		.hd_item  (hd_item)
	);

	// run timer engine
	stq_back #(
		.DEPTH    (DEPTH),
		.TAG_BITS (TAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hd_valid  (hd_valid),
		.hd_take   (hd_take),
		.hd_item   (hd_item),
		.res_valid (result_valid),
		.res_ready (result_ready),
		.res_kind  (kind),
		.res_tag   (fired_tag),
		.res_last  (last)
	);

endmodule
